@@ hw/rtl/melody_note_sequencer_macros.svh @@
// Assertion macros used by the checker file msq_checker.sv.
`ifndef MELODY_NOTE_SEQUENCER_MACROS_SVH
`define MELODY_NOTE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/msq_pkg.sv @@
package msq_pkg;

    localparam int MAX_NOTES = 256;
    localparam int ADDR_W    = $clog2(MAX_NOTES);
    localparam int IDX_W     = 8;
    localparam int IDX_EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int LEN_CAP   = (MAX_NOTES < 256) ? MAX_NOTES : 256;

    // Event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_STOP  = 2'd2;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_QUARTER_MS   = 2'd0;
    localparam logic [1:0] REG_PAUSE_LENGTH = 2'd1;
    localparam logic [1:0] REG_SONG_LENGTH  = 2'd2;

    localparam logic [15:0] QUARTER_MS_RST   = 16'd500;
    localparam logic [15:0] PAUSE_LENGTH_RST = 16'd0;
    localparam logic [8:0]  SONG_LENGTH_RST  = 9'd1;

    typedef struct packed {
        logic [15:0] quarter_ms;
        logic [15:0] pause_length;
        logic [8:0]  eff_len;
    } cfg_t;

    // Advance an index by one, wrapping at the effective song length.
    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                   input logic [8:0] eff_len);
        logic [8:0] s;
        s = {1'b0, idx} + 9'd1;
        return (s >= eff_len) ? '0 : s[IDX_W-1:0];
    endfunction

    function automatic logic in_table(input logic [IDX_W-1:0] idx);
        logic [IDX_EXT_W:0] e;
        e = (IDX_EXT_W + 1)'(idx);
        return e < (IDX_EXT_W + 1)'(MAX_NOTES);
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_EXT_W-1:0] e;
        e = IDX_EXT_W'(idx);
        return e[ADDR_W-1:0];
    endfunction

endpackage

@@ hw/rtl/msq_ram.sv @@
module msq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the contents before a same-cycle write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/msq_cfg.sv @@
module msq_cfg
    import msq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    logic [15:0] quarter_ms_reg;
    logic [15:0] pause_length_reg;
    logic [8:0]  song_length_reg;
    logic [8:0]  eff_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quarter_ms_reg   <= QUARTER_MS_RST;
            pause_length_reg <= PAUSE_LENGTH_RST;
            song_length_reg  <= SONG_LENGTH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_QUARTER_MS:   quarter_ms_reg   <= cfg_data;
                REG_PAUSE_LENGTH: pause_length_reg <= cfg_data;
                REG_SONG_LENGTH:  song_length_reg  <= cfg_data[8:0];
                default:          ;
            endcase
        end
    end

    // Clamp to the table size, and treat zero as one note.
    always_comb
    begin
        eff_len = song_length_reg;
        if (eff_len > 9'(LEN_CAP))
        begin
            eff_len = 9'(LEN_CAP);
        end
        if (eff_len == 9'd0)
        begin
            eff_len = 9'd1;
        end
    end

    assign cfg_ready        = 1'b1;
    assign cfg.quarter_ms   = quarter_ms_reg;
    assign cfg.pause_length = pause_length_reg;
    assign cfg.eff_len      = eff_len;

endmodule

@@ hw/rtl/msq_core.sv @@
module msq_core
    import msq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] delta_ms,
    input  logic [7:0]  entry_index,
    input  logic [15:0] entry_freq,
    input  logic [15:0] entry_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [15:0] tone_freq,
    output logic [23:0] tone_duration_ms,
    output logic [15:0] current_freq,
    output logic [7:0]  current_index
);

    // Input register
    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [15:0] s1_delta_reg;
    logic [7:0]  s1_idx_reg;
    logic [15:0] s1_freq_reg;
    logic [15:0] s1_len_reg;

    // Sequencer state
    logic [7:0]  note_index_reg, note_index_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic        playing_reg, playing_next;
    logic [15:0] cur_freq_reg, cur_freq_next;
    logic [15:0] cur_len_reg, cur_len_next;

    // Prefetch of the note after the current one
    logic [7:0]  rd_idx_reg;
    logic        byp_hit_reg;
    logic [31:0] byp_data_reg;
    logic [31:0] ram_rdata;
    logic [31:0] nxt_entry;
    logic [7:0]  nxt_idx_now;
    logic [7:0]  rd_idx;
    logic        fetch_ok;
    logic        ram_we;

    // Output register
    logic        out_valid_reg;
    logic [1:0]  event_reg, event_next;
    logic [15:0] tone_freq_reg, tone_freq_next;
    logic [23:0] tone_dur_reg, tone_dur_next;
    logic [15:0] cur_freq_out_reg;
    logic [7:0]  cur_index_out_reg;

    logic               fire;
    logic               load_hit_table;
    logic [32:0]        sum;
    logic [31:0]        elapsed_sat;
    logic [39:0]        scaled;
    logic [31:0]        pause_thr;
    logic               pause_hit;
    logic signed [16:0] cur_diff, nxt_diff;
    logic signed [33:0] cur_thr, nxt_thr;
    logic signed [41:0] cur_thr_ext;
    logic signed [41:0] scaled_s;
    logic               stop_hit;

    assign nxt_entry   = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign nxt_idx_now = next_index(note_index_reg, cfg.eff_len);
    // Hold the item until the prefetched entry matches the current next index.
    assign fetch_ok    = (rd_idx_reg == nxt_idx_now);
    assign fire        = s1_valid_reg && fetch_ok && (!out_valid_reg || !out_stall);
    assign in_stall    = s1_valid_reg && !fire;

    assign load_hit_table = (s1_kind_reg == KIND_LOAD) && in_table(s1_idx_reg);
    assign ram_we         = fire && load_hit_table;

    always_comb
    begin
        sum         = {1'b0, elapsed_reg} + {17'd0, s1_delta_reg};
        elapsed_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        scaled      = {elapsed_sat, 8'd0};
        pause_thr   = 32'(cfg.pause_length) * 32'(cfg.quarter_ms);
        pause_hit   = scaled >= {8'd0, pause_thr};
        cur_diff    = $signed({1'b0, cur_len_reg}) - $signed({1'b0, cfg.pause_length});
        nxt_diff    = $signed({1'b0, nxt_entry[15:0]}) - $signed({1'b0, cfg.pause_length});
        cur_thr     = 34'(cur_diff) * 34'($signed({1'b0, cfg.quarter_ms}));
        nxt_thr     = 34'(nxt_diff) * 34'($signed({1'b0, cfg.quarter_ms}));
        cur_thr_ext = 42'(cur_thr);
        scaled_s    = $signed({2'b00, scaled});
        stop_hit    = scaled_s >= cur_thr_ext;
    end

    always_comb
    begin
        note_index_next = note_index_reg;
        elapsed_next    = elapsed_reg;
        playing_next    = playing_reg;
        cur_freq_next   = cur_freq_reg;
        cur_len_next    = cur_len_reg;
        event_next      = EV_NONE;
        tone_freq_next  = '0;
        tone_dur_next   = '0;
        if (s1_kind_reg == KIND_LOAD)
        begin
            if (load_hit_table && (s1_idx_reg == note_index_reg))
            begin
                cur_freq_next = s1_freq_reg;
                cur_len_next  = s1_len_reg;
            end
        end
        else
        begin
            elapsed_next = elapsed_sat;
            if (playing_reg)
            begin
                if (stop_hit)
                begin
                    elapsed_next = '0;
                    playing_next = 1'b0;
                    event_next   = EV_STOP;
                end
            end
            else if (pause_hit)
            begin
                note_index_next = nxt_idx_now;
                elapsed_next    = '0;
                playing_next    = 1'b1;
                cur_freq_next   = nxt_entry[31:16];
                cur_len_next    = nxt_entry[15:0];
                event_next      = EV_START;
                tone_freq_next  = nxt_entry[31:16];
                tone_dur_next   = (nxt_thr > 34'sd0) ? nxt_thr[31:8] : 24'd0;
            end
        end
    end

    // Fetch the note after the index that holds once this cycle's item is done.
    assign rd_idx = next_index(fire ? note_index_next : note_index_reg, cfg.eff_len);

    msq_ram #(
        .WIDTH (32),
        .DEPTH (MAX_NOTES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (to_addr(s1_idx_reg)),
        .wdata ({s1_freq_reg, s1_len_reg}),
        .raddr (to_addr(rd_idx)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            note_index_reg <= '0;
            elapsed_reg    <= '0;
            playing_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            byp_hit_reg    <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                note_index_reg <= note_index_next;
                elapsed_reg    <= elapsed_next;
                playing_reg    <= playing_next;
            end

            rd_idx_reg  <= rd_idx;
            // Forward a write that lands on the address read in the same cycle.
            byp_hit_reg <= ram_we && (to_addr(s1_idx_reg) == to_addr(rd_idx));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_kind_reg  <= kind;
            s1_delta_reg <= delta_ms;
            s1_idx_reg   <= entry_index;
            s1_freq_reg  <= entry_freq;
            s1_len_reg   <= entry_length;
        end
        byp_data_reg <= {s1_freq_reg, s1_len_reg};
        if (fire)
        begin
            cur_freq_reg      <= cur_freq_next;
            cur_len_reg       <= cur_len_next;
            event_reg         <= event_next;
            tone_freq_reg     <= tone_freq_next;
            tone_dur_reg      <= tone_dur_next;
            cur_freq_out_reg  <= cur_freq_next;
            cur_index_out_reg <= note_index_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_res        = event_reg;
    assign tone_freq        = tone_freq_reg;
    assign tone_duration_ms = tone_dur_reg;
    assign current_freq     = cur_freq_out_reg;
    assign current_index    = cur_index_out_reg;

endmodule

@@ hw/rtl/melody_note_sequencer.sv @@
// Melody note sequencer.
// Input channel (in_valid / in_stall): kind 1 loads one note table entry
// (entry_index, entry_freq, entry_length); kind 0 is a time tick of delta_ms.
// Config channel (cfg_valid / cfg_ready, always ready): cfg_index 0 quarter_ms,
// 1 pause_length, 2 song_length; other indexes are dropped. Write while idle.
// Output channel (out_valid / out_stall): exactly one result per item, with
// event_res none/start/stop, the started tone, and the current note.
// Each item is held in the input register, then its result in the result
// register. Throughput: one item per cycle unless a stall holds it.
// The note table is one 256 x 32 RAM with a registered read; the entry after
// the current note is prefetched every cycle, so a start uses it at once. The
// first item after a song_length write may wait for that prefetch. A stalled
// result holds; the input register keeps taking one more item, and in_stall
// rises when that register is full and cannot pass its item on.
// Reset: index 0, elapsed 0, pause phase, registers at their reset values;
// table contents are unknown until loaded.
module melody_note_sequencer
    import msq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] delta_ms,
    input  logic [7:0]  entry_index,
    input  logic [15:0] entry_freq,
    input  logic [15:0] entry_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [15:0] tone_freq,
    output logic [23:0] tone_duration_ms,
    output logic [15:0] current_freq,
    output logic [7:0]  current_index
);

    cfg_t cfg;

    msq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msq_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .delta_ms         (delta_ms),
        .entry_index      (entry_index),
        .entry_freq       (entry_freq),
        .entry_length     (entry_length),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_res        (event_res),
        .tone_freq        (tone_freq),
        .tone_duration_ms (tone_duration_ms),
        .current_freq     (current_freq),
        .current_index    (current_index)
    );

endmodule

@@ hw/rtl/msq_checker.sv @@
`include "melody_note_sequencer_macros.svh"

module msq_checker
    import msq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  event_res,
    input logic [15:0] tone_freq,
    input logic [23:0] tone_duration_ms,
    input logic [15:0] current_freq,
    input logic [7:0]  current_index
);

    logic start_taken;

    assign start_taken = out_valid && !out_stall && (event_res == EV_START);

    `MSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(event_res) && $stable(current_index), "stalled result changed")

    `MSQ_ASSERT_IMPL(a_event_code, clk, rst_n, out_valid,
        event_res == EV_NONE || event_res == EV_START || event_res == EV_STOP,
        "unknown event code")

    `MSQ_ASSERT_IMPL(a_quiet_tone, clk, rst_n, out_valid && event_res != EV_START,
        tone_freq == 16'd0 && tone_duration_ms == 24'd0, "tone fields set without a start")

    `MSQ_ASSERT_IMPL(a_start_note, clk, rst_n, out_valid && event_res == EV_START,
        current_freq == tone_freq, "started tone differs from current note")

    // A start enters the play phase, so the next delivered result is never a start.
    `MSQ_ASSERT_NEXT(a_no_double_start, clk, rst_n, start_taken,
        !(out_valid && event_res == EV_START), "start followed directly by start")

endmodule

bind melody_note_sequencer msq_checker u_msq_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import msq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [15:0] delta_ms;
        logic [7:0]  entry_index;
        logic [15:0] entry_freq;
        logic [15:0] entry_length;
    } seq_item_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [15:0] tone_freq;
        logic [23:0] tone_duration_ms;
        logic [15:0] current_freq;
        logic [7:0]  current_index;
    } tone_report_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [1:0]  cfg_index    = '0;
    logic [15:0] cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic        kind         = KIND_TICK;
    logic [15:0] delta_ms     = '0;
    logic [7:0]  entry_index  = '0;
    logic [15:0] entry_freq   = '0;
    logic [15:0] entry_length = '0;
    logic        out_stall    = 1'b0;
    logic        cfg_ready;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  event_res;
    logic [15:0] tone_freq;
    logic [23:0] tone_duration_ms;
    logic [15:0] current_freq;
    logic [7:0]  current_index;

    // Shadow of the sequencer state, advanced once per accepted transaction
    logic [15:0] freq_tab [MAX_NOTES];
    logic [15:0] len_tab [MAX_NOTES];
    logic [7:0]  note_pos  = '0;
    logic [31:0] elapsed   = '0;
    logic        tone_on   = 1'b0;
    logic [15:0] quarter_q = QUARTER_MS_RST;
    logic [15:0] pause_q   = PAUSE_LENGTH_RST;
    logic [8:0]  song_q    = SONG_LENGTH_RST;

    tone_report_t expected_tones [$];
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int stall_left     = 0;
    bit idling         = 1'b1;

    melody_note_sequencer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .delta_ms         (delta_ms),
        .entry_index      (entry_index),
        .entry_freq       (entry_freq),
        .entry_length     (entry_length),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_res        (event_res),
        .tone_freq        (tone_freq),
        .tone_duration_ms (tone_duration_ms),
        .current_freq     (current_freq),
        .current_index    (current_index)
    );

    always #4 clk = ~clk;

    // Play span of the current note: (length - pause) * quarter, signed Q24.8 ms
    function automatic longint play_span();
        longint len_v;
        longint pause_v;
        longint quarter_v;
        len_v     = len_tab[note_pos];
        pause_v   = pause_q;
        quarter_v = quarter_q;
        return (len_v - pause_v) * quarter_v;
    endfunction

    task automatic advance_sequencer(input seq_item_t it, output tone_report_t r);
        longint sum;
        longint scaled;
        longint gate;
        longint span;
        int     eff;
        r = '0;
        r.event_res = EV_NONE;
        if (it.kind == KIND_LOAD)
        begin
            if (int'(it.entry_index) < MAX_NOTES)
            begin
                freq_tab[it.entry_index] = it.entry_freq;
                len_tab[it.entry_index]  = it.entry_length;
            end
        end
        else
        begin
            sum = elapsed;
            sum = sum + it.delta_ms;
            elapsed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            scaled = elapsed;
            scaled = scaled * 256;
            if (tone_on)
            begin
                if (scaled >= play_span())
                begin
                    elapsed     = '0;
                    tone_on     = 1'b0;
                    r.event_res = EV_STOP;
                end
            end
            else
            begin
                gate = pause_q;
                gate = gate * quarter_q;
                if (scaled >= gate)
                begin
                    eff = song_q;
                    if (eff > MAX_NOTES) eff = MAX_NOTES;
                    if (eff > 256) eff = 256;
                    if (eff == 0) eff = 1;
                    note_pos = (int'(note_pos) + 1 >= eff) ? 8'd0 : note_pos + 8'd1;
                    elapsed  = '0;
                    tone_on  = 1'b1;
                    span     = play_span();
                    r.event_res        = EV_START;
                    r.tone_freq        = freq_tab[note_pos];
                    r.tone_duration_ms = (span > 0) ? 24'(span >>> 8) : 24'd0;
                end
            end
        end
        r.current_freq  = freq_tab[note_pos];
        r.current_index = note_pos;
    endtask

    task automatic send_item(input seq_item_t it);
        tone_report_t r;
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= it.kind;
        delta_ms     <= it.delta_ms;
        entry_index  <= it.entry_index;
        entry_freq   <= it.entry_freq;
        entry_length <= it.entry_length;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        advance_sequencer(it, r);
        expected_tones.push_back(r);
    endtask

    // Unused fields carry random bits; the block ignores them
    task automatic send_tick(input logic [15:0] delta);
        seq_item_t it;
        it.kind         = KIND_TICK;
        it.delta_ms     = delta;
        it.entry_index  = 8'($urandom);
        it.entry_freq   = 16'($urandom);
        it.entry_length = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [15:0] freq,
                             input logic [15:0] len);
        seq_item_t it;
        it.kind         = KIND_LOAD;
        it.delta_ms     = 16'($urandom);
        it.entry_index  = idx;
        it.entry_freq   = freq;
        it.entry_length = len;
        send_item(it);
    endtask

    // Drop valid, then hold until every expected result is in and the pipe is empty
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_tones.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_QUARTER_MS:   quarter_q = data;
            REG_PAUSE_LENGTH: pause_q   = data;
            REG_SONG_LENGTH:  song_q    = data[8:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] quarter, input logic [15:0] pause,
                              input logic [15:0] song);
        write_reg(REG_QUARTER_MS, quarter);
        write_reg(REG_PAUSE_LENGTH, pause);
        write_reg(REG_SONG_LENGTH, song);
        write_reg(REG_UNUSED, 16'($urandom));
    endtask

    // Keep most deltas near the quarter note so both phases finish often
    function automatic logic [15:0] pick_delta();
        int hi;
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        hi = 2 * int'(quarter_q);
        if (hi > 65535) hi = 65535;
        return 16'($urandom_range(0, hi));
    endfunction

    function automatic logic [15:0] pick_length();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 16'h0400));
    endfunction

    task automatic test_reset_defaults();
        send_load(8'd0, 16'hFFFF, 16'hFFFF);
        send_tick(16'd0);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        send_tick(16'd0);
    endtask

    task automatic test_register_corners();
        // zero quarter: every tick flips the phase; zero song length acts as one
        set_config(16'd0, 16'hFFFF, 16'd0);
        repeat (3) send_tick(16'hFFFF);
        send_load(8'd0, 16'd0, 16'd0);
        send_load(8'd255, 16'hFFFF, 16'h0000);
        // pause longer than the note: duration clamps, next tick stops
        set_config(16'd500, 16'h0100, 16'h0001);
        send_tick(16'd0);
        send_tick(16'd500);
        send_tick(16'd0);
        send_tick(16'd500);
        send_tick(16'd0);
        set_config(16'd60000, 16'd0, 16'hFE01);
        send_load(8'd0, 16'h1234, 16'h0180);
        repeat (3) send_tick(16'hFFFF);
    endtask

    task automatic test_table_fill();
        for (int i = 0; i < MAX_NOTES; i++)
            send_load(8'(i), 16'($urandom), pick_length());
    endtask

    task automatic test_index_wrap();
        // song length above the table: run the index past 255 and back to 0
        set_config(16'd0, 16'd0, 16'hFFFF);
        repeat (530) send_tick(pick_delta());
    endtask

    task automatic test_random_playback(input int phases, input int items);
        logic [15:0] quarter;
        logic [15:0] pause;
        int          song;
        for (int p = 0; p < phases; p++)
        begin
            case ($urandom_range(0, 4))
                0:       quarter = 16'd0;
                1:       quarter = 16'd1;
                2:       quarter = 16'hFFFF;
                3:       quarter = 16'd60000;
                default: quarter = 16'($urandom_range(1, 60000));
            endcase
            pause = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 16'h0200));
            song  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8)
                                                : $urandom_range(0, 511);
            set_config(quarter, pause, {7'($urandom), 9'(song)});
            if (p == phases - 1) idling = 1'b0;
            repeat (items)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_load(8'($urandom), 16'($urandom), pick_length());
                else
                    send_tick(pick_delta());
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (!idling)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        tone_report_t got;
        tone_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {event_res, tone_freq, tone_duration_ms, current_freq, current_index};
            if (expected_tones.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with none pending: ev=%0d idx=%0d", $time,
                             got.event_res, got.current_index);
            end
            else
            begin
                want = expected_tones.pop_front();
                if (got.event_res !== want.event_res || got.tone_freq !== want.tone_freq ||
                    got.tone_duration_ms !== want.tone_duration_ms ||
                    got.current_freq !== want.current_freq ||
                    got.current_index !== want.current_index)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $write("%0t: mismatch exp ev=%0d freq=%0d dur=%0d cur=%0d idx=%0d",
                               $time, want.event_res, want.tone_freq,
                               want.tone_duration_ms, want.current_freq,
                               want.current_index);
                        $display(" got ev=%0d freq=%0d dur=%0d cur=%0d idx=%0d",
                                 got.event_res, got.tone_freq, got.tone_duration_ms,
                                 got.current_freq, got.current_index);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles++;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_register_corners();
        test_table_fill();
        test_index_wrap();
        test_random_playback(8, 100);
        wait_idle();
        if (mismatch_count == 0 && expected_tones.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
